// File: hw/rtl/cdid_pkg.sv
package cdid_pkg;

  localparam int unsigned LbaW       = 19;
  localparam int unsigned FramesW    = 20;  // lba + lead-in before the 19-bit wrap
  localparam int unsigned SecsW      = 13;
  localparam int unsigned DsumW      = 6;   // digit sum of at most four digits
  localparam int unsigned ChkW       = 12;
  localparam int unsigned CountW     = 7;
  localparam int unsigned IdW        = 32;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 56;

  localparam int unsigned MaxTracks  = 99;
  localparam int unsigned LeadIn     = 150;

  // floor(x / 75) = (x * SecsMul) >> SecsShift, exact for x < 2^26 / 11
  localparam int unsigned SecsMul    = 894785;
  localparam int unsigned SecsShift  = 26;
  localparam int unsigned SecsProdW  = 40;

  // floor(x / 10) for x < 16384 and for x < 1029
  localparam int unsigned Div10MulA  = 3277;
  localparam int unsigned Div10ShA   = 15;
  localparam int unsigned Div10MulB  = 205;
  localparam int unsigned Div10ShB   = 11;

  localparam int unsigned ChkMod     = 255;
  localparam int unsigned ChkPos     = 24;
  localparam int unsigned TotalPos   = 8;

  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);

  typedef struct packed {
    logic [LbaW-1:0]  frames;    // lba + lead-in, 19-bit wrap
    logic [SecsW-1:0] secs;
    logic [DsumW-1:0] dsum;
    logic             leadout;
  } cdid_item_t;

endpackage

// File: hw/rtl/cd_disc_id_calc.sv
// CD database disc-id calculator. Feed the table of contents one entry per
// item: track start LBAs with tlast low, then the lead-out LBA with tlast high.
// Each track returns lba + 150; the lead-out returns its start in seconds and
// the packed disc id (checksum mod 255 in [31:24], total seconds in [23:8],
// track count in [7:0]), after which the accumulators clear for the next disc.
// Tracks beyond 99 pass through but are not counted. Throughput is one item
// per clock while the queue is not full; a result passes through the
// four-stage seconds/digit pipeline, the queue write and the result register
// before it is valid. The four-entry queue lets input keep flowing while the
// output is stalled.
module cd_disc_id_calc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [cdid_pkg::InDataW-1:0]     s_axis_tdata_i,  // [18:0] lba
  input  logic                             s_axis_tlast_i,  // is_leadout
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [cdid_pkg::OutDataW-1:0]    m_axis_tdata_o,  // [18:0] frame_offset,
                                                            // [50:19] disc_id
  output logic                             m_axis_tlast_o   // is_last
);
  import cdid_pkg::*;

  logic       push, full, q_valid, pop;
  cdid_item_t push_item, q_item;
  logic [LbaW-1:0] frame_offset;
  logic [IdW-1:0]  disc_id;

  cdid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .lba_i      (s_axis_tdata_i[LbaW-1:0]),
    .leadout_i  (s_axis_tlast_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (push_item)
  );

  cdid_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cdid_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .frame_offset_o (frame_offset),
    .disc_id_o      (disc_id),
    .is_last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(OutDataW-IdW-LbaW)'(0), disc_id, frame_offset};

endmodule

// File: hw/rtl/cdid_front.sv
module cdid_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cdid_pkg::LbaW-1:0]  lba_i,
  input  logic                       leadout_i,
  output logic                       push_o,
  input  logic                       full_i,
  output cdid_pkg::cdid_item_t       item_o
);
  import cdid_pkg::*;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: frames and seconds
  logic [LbaW-1:0]      fr1_q;
  logic [SecsW-1:0]     secs1_q;
  logic                 lo1_q;
  logic [FramesW-1:0]   frames;
  logic [SecsProdW-1:0] prod1;

  // stage 2: units digit
  logic [LbaW-1:0]  fr2_q;
  logic [SecsW-1:0] secs2_q;
  logic             lo2_q;
  logic [9:0]       q1_q;
  logic [3:0]       d0_q;
  logic [24:0]      prod2;
  logic [9:0]       q1;
  logic [SecsW-1:0] rem2;

  // stage 3: tens digit
  logic [LbaW-1:0]  fr3_q;
  logic [SecsW-1:0] secs3_q;
  logic             lo3_q;
  logic [6:0]       q2_q;
  logic [4:0]       part_q;
  logic [17:0]      prod3;
  logic [6:0]       q2;
  logic [9:0]       rem3;

  // stage 4: hundreds and thousands digits
  cdid_item_t       item_q;
  logic [14:0]      prod4;
  logic [2:0]       q3;
  logic [6:0]       rem4;

  assign rdy4 = !v4_q || !full_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign push_o = v4_q && !full_i;
  assign item_o = item_q;

  assign frames = FramesW'(lba_i) + FramesW'(LeadIn);
  assign prod1  = SecsProdW'(frames) * SecsProdW'(SecsMul);

  assign prod2 = 25'(secs1_q) * 25'(Div10MulA);
  assign q1    = prod2[Div10ShA +: 10];
  assign rem2  = secs1_q - SecsW'(SecsW'(q1) * SecsW'(10));

  assign prod3 = 18'(q1_q) * 18'(Div10MulB);
  assign q2    = prod3[Div10ShB +: 7];
  assign rem3  = q1_q - 10'(10'(q2) * 10'(10));

  assign prod4 = 15'(q2_q) * 15'(Div10MulB);
  assign q3    = prod4[Div10ShB +: 3];
  assign rem4  = q2_q - 7'(7'(q3) * 7'(10));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      fr1_q   <= frames[LbaW-1:0];
      secs1_q <= prod1[SecsShift +: SecsW];
      lo1_q   <= leadout_i;
    end
    if (rdy2) begin
      fr2_q   <= fr1_q;
      secs2_q <= secs1_q;
      lo2_q   <= lo1_q;
      q1_q    <= q1;
      d0_q    <= rem2[3:0];
    end
    if (rdy3) begin
      fr3_q   <= fr2_q;
      secs3_q <= secs2_q;
      lo3_q   <= lo2_q;
      q2_q    <= q2;
      part_q  <= 5'(d0_q) + 5'(rem3[3:0]);
    end
    if (rdy4) begin
      item_q.frames  <= fr3_q;
      item_q.secs    <= secs3_q;
      item_q.leadout <= lo3_q;
      item_q.dsum    <= DsumW'(part_q) + DsumW'(rem4[3:0]) + DsumW'(q3);
    end
  end

endmodule

// File: hw/rtl/cdid_fifo.sv
module cdid_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cdid_pkg::cdid_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output cdid_pkg::cdid_item_t item_o
);
  import cdid_pkg::*;

  cdid_item_t       mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

endmodule

// File: hw/rtl/cdid_back.sv
module cdid_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  cdid_pkg::cdid_item_t          q_item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cdid_pkg::LbaW-1:0]     frame_offset_o,
  output logic [cdid_pkg::IdW-1:0]      disc_id_o,
  output logic                          is_last_o
);
  import cdid_pkg::*;

  logic [ChkW-1:0]   chk_q;
  logic [SecsW-1:0]  first_q;
  logic [CountW-1:0] cnt_q;
  logic              out_v_q;
  logic [LbaW-1:0]   fo_q;
  logic [IdW-1:0]    id_q;
  logic              last_q;

  logic              counting;
  logic [SecsW-1:0]  total;
  logic [8:0]        fold;
  logic [7:0]        chk_mod;
  logic [IdW-1:0]    id;

  assign pop_o          = q_valid_i && (!out_v_q || out_ready_i);
  assign out_valid_o    = out_v_q;
  assign frame_offset_o = fo_q;
  assign disc_id_o      = id_q;
  assign is_last_o      = last_q;

  assign counting = (cnt_q < CountW'(MaxTracks));

  always_comb begin
    total = '0;
    if (cnt_q != '0 && q_item_i.secs > first_q) total = q_item_i.secs - first_q;
    // 256 = 1 mod 255, so fold the high nibble onto the low byte
    fold = 9'(chk_q[ChkW-1:8]) + 9'(chk_q[7:0]);
    if (fold >= 9'(ChkMod)) begin
      chk_mod = 8'(fold - 9'(ChkMod));
    end else begin
      chk_mod = fold[7:0];
    end
    id = (IdW'(chk_mod) << ChkPos) | (IdW'(total) << TotalPos) | IdW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q   <= '0;
      first_q <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (pop_o) begin
        if (q_item_i.leadout) begin
          chk_q   <= '0;
          first_q <= '0;
          cnt_q   <= '0;
        end else if (counting) begin
          if (cnt_q == '0) first_q <= q_item_i.secs;
          chk_q <= chk_q + ChkW'(q_item_i.dsum);
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (q_item_i.leadout) begin
        fo_q   <= LbaW'(q_item_i.secs);
        id_q   <= id;
        last_q <= 1'b1;
      end else begin
        fo_q   <= q_item_i.frames;
        id_q   <= '0;
        last_q <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/cdid_checker.sv
module cdid_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [cdid_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                          s_axis_tlast_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [cdid_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);
  import cdid_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  a_track_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[50:19] == '0)
    else $error("track item carries a disc id");

  a_id_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o[26:19] <= 8'(MaxTracks) && m_axis_tdata_o[50:43] != 8'hff)
    else $error("disc id count or checksum out of range");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      19'(m_axis_tdata_o[42:27]) <= m_axis_tdata_o[18:0])
    else $error("total seconds exceed lead-out seconds");

endmodule

bind cd_disc_id_calc cdid_checker u_cdid_checker (.*);
